/* design/bps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and fixed widths of the block parity signature engine.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned AidW     = 2;
  localparam int unsigned IdxW     = 13;
  localparam int unsigned ChunkW   = 6;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned SlotOutW = 8;

  // index / chunk divider: quotient digits retired per cycle
  localparam int unsigned DivStep  = 4;
  localparam int unsigned DivIters = (IdxW + DivStep - 1) / DivStep;
  localparam int unsigned DivW     = DivIters * DivStep;
  localparam int unsigned DivCntW  = $clog2(DivIters);

  localparam int unsigned QueueDepth = 2;

  localparam logic [ChunkW-1:0] ChunkReset = 6'd8;

  typedef enum logic [1:0] {
    CMD_GEN,
    CMD_CHECK,
    CMD_UPDATE,
    CMD_UNUSED
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED,
    ST_STORED,
    ST_VERIFIED,
    ST_MISMATCH,
    ST_NO_SIG,
    ST_RANGE
  } status_e;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_RANGE,
    OP_UPDATE,
    OP_RUN
  } op_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic              check;
    logic              last;
    logic [AidW-1:0]   aid;
    logic [IdxW-1:0]   slot;
    logic [ChunkW-1:0] pos;
    logic [ChunkW-1:0] chunk;
    logic [WordW-1:0]  value;
    logic [WordW-1:0]  old_value;
  } item_t;

endpackage

/* design/bps_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_if
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
interface bps_item_if;
  import bps_pkg::*;

  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [AidW-1:0]  array_id;
  logic [IdxW-1:0]  elem_index;
  logic [WordW-1:0] value;
  logic [WordW-1:0] old_value;

  modport source (output valid, cmd, array_id, elem_index, value, old_value, input ready);
  modport sink   (input valid, cmd, array_id, elem_index, value, old_value, output ready);
endinterface

interface bps_result_if;
  import bps_pkg::*;

  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic [SlotOutW-1:0] chunk_slot;
  logic [WordW-1:0]    row_parity_word;

  modport source (output valid, status, chunk_slot, row_parity_word, input ready);
  modport sink   (input valid, status, chunk_slot, row_parity_word, output ready);
endinterface

/* design/bps_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bps_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_front
// Takes input beats, splits the index into chunk slot and position with a
// radix-16 divider, classifies the command and hands the item to the queue.
// ----------------------------------------------------------------------------
module bps_front #(
  parameter int unsigned CHUNK_MAX       = 32,
  parameter int unsigned SLOTS_PER_ARRAY = 256,
  parameter int unsigned ARRAY_COUNT     = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bps_pkg::ChunkW-1:0] cfg_wdata_i,
  input  logic                       clearing_i,
  bps_item_if.sink                   item_i,
  input  logic                       full_i,
  output logic                       push_o,
  output bps_pkg::item_t             item_o
);
  import bps_pkg::*;

  localparam logic [ChunkW-1:0] ChunkMaxC = ChunkW'(CHUNK_MAX);

  front_state_e        state_q, state_d;
  logic [ChunkW-1:0]   cfg_chunk_q;
  logic [ChunkW-1:0]   chunk_eff;
  logic [DivCntW-1:0]  cnt_q;
  logic                accept;

  cmd_e                cmd_q;
  logic [AidW-1:0]     aid_q;
  logic [WordW-1:0]    value_q;
  logic [WordW-1:0]    old_q;
  logic [ChunkW-1:0]   chunk_q;
  logic [DivW-1:0]     num_q, num_d;
  logic [DivW-1:0]     quot_q, quot_d;
  logic [ChunkW-1:0]   rem_q, rem_d;

  assign item_i.ready = (state_q == F_IDLE) && !clearing_i;
  assign accept       = item_i.valid && item_i.ready;

  always_comb begin
    if (cfg_chunk_q == '0) begin
      chunk_eff = ChunkW'(1);
    end else if (cfg_chunk_q > ChunkMaxC) begin
      chunk_eff = ChunkMaxC;
    end else begin
      chunk_eff = cfg_chunk_q;
    end
  end

  always_comb begin
    logic [ChunkW:0] part;
    num_d  = num_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    for (int s = 0; s < DivStep; s++) begin
      part  = {rem_d, num_d[DivW-1]};
      num_d = {num_d[DivW-2:0], 1'b0};
      if (part >= {1'b0, chunk_q}) begin
        part   = part - {1'b0, chunk_q};
        quot_d = {quot_d[DivW-2:0], 1'b1};
      end else begin
        quot_d = {quot_d[DivW-2:0], 1'b0};
      end
      rem_d = part[ChunkW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        if (cnt_q == DivCntW'(DivIters - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    item_o.aid       = aid_q;
    item_o.slot      = quot_q[IdxW-1:0];
    item_o.pos       = rem_q;
    item_o.chunk     = chunk_q;
    item_o.value     = value_q;
    item_o.old_value = old_q;
    item_o.check     = (cmd_q == CMD_CHECK);
    item_o.last      = (rem_q == chunk_q - ChunkW'(1));
    if (cmd_q == CMD_UNUSED) begin
      item_o.op = OP_NOP;
    end else if (quot_q[IdxW-1:0] >= IdxW'(SLOTS_PER_ARRAY) || int'(aid_q) >= ARRAY_COUNT) begin
      item_o.op = OP_RANGE;
    end else if (cmd_q == CMD_UPDATE) begin
      item_o.op = OP_UPDATE;
    end else begin
      item_o.op = OP_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      cfg_chunk_q <= ChunkReset;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_chunk_q <= cfg_wdata_i;
      end
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == F_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(item_i.cmd);
      aid_q   <= item_i.array_id;
      value_q <= item_i.value;
      old_q   <= item_i.old_value;
      chunk_q <= chunk_eff;
      num_q   <= DivW'(item_i.elem_index);
      quot_q  <= '0;
      rem_q   <= '0;
    end else if (state_q == F_DIV) begin
      num_q  <= num_d;
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  // all dividend digits consumed by the time the item is handed on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_PUSH |-> num_q == '0)
    else $error("divider did not consume the whole index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> item_o.pos < item_o.chunk)
    else $error("chunk position not below chunk size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_DIV |-> chunk_q != '0 && chunk_q <= ChunkMaxC)
    else $error("divisor outside clamped range");

endmodule

/* design/bps_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module bps_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bps_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bps_pkg::item_t item_o
);
  import bps_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t           entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW + 1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* design/bps_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_back
// Runs items against the running XOR/parity state and the signature table:
// table read, then update, store or compare as the item calls for, and one result beat.
// ----------------------------------------------------------------------------
module bps_back #(
  parameter int unsigned CHUNK_MAX       = 32,
  parameter int unsigned SLOTS_PER_ARRAY = 256,
  parameter int unsigned ARRAY_COUNT     = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  bps_pkg::item_t item_i,
  output logic           pop_o,
  output logic           clearing_o,
  bps_result_if.source   result_o
);
  import bps_pkg::*;

  localparam int unsigned ParW   = CHUNK_MAX + 1;
  localparam int unsigned Depth  = ARRAY_COUNT * SLOTS_PER_ARRAY;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned SlotW  = $clog2(SLOTS_PER_ARRAY);
  localparam int unsigned EntryW = 1 + ParW + WordW;

  back_state_e          state_q, state_d;
  logic [AddrW-1:0]     clr_cnt_q;
  logic [WordW-1:0]     run_xor_q;
  logic [CHUNK_MAX-1:0] run_par_q;
  logic                 out_valid_q;
  status_e              status_q;
  logic [SlotOutW-1:0]  slot_q;
  logic [WordW-1:0]     word_q;
  item_t                item_q;
  logic [AddrW-1:0]     addr_q;

  logic                 ram_we, ram_re;
  logic [AddrW-1:0]     ram_waddr, ram_raddr;
  logic [EntryW-1:0]    ram_wdata, ram_rdata;

  logic                 out_free, load_out;
  logic                 exec_we;
  logic [EntryW-1:0]    exec_wdata;
  status_e              exec_status;
  logic [WordW-1:0]     exec_word;
  logic                 run_upd, run_clr;
  logic [WordW-1:0]     run_xor_n;
  logic [CHUNK_MAX-1:0] run_par_n;

  assign ram_raddr = AddrW'(item_i.aid) * AddrW'(SLOTS_PER_ARRAY)
                   + AddrW'(item_i.slot[SlotW-1:0]);

  bps_ram #(
    .WIDTH (EntryW),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !out_valid_q || result_o.ready;
  assign clearing_o = (state_q == B_CLEAR);

  always_comb begin
    logic              pv;
    logic              st_valid;
    logic [ParW-1:0]   st_par;
    logic [WordW-1:0]  st_xor;
    logic [WordW-1:0]  upd_xor;
    logic [ParW-1:0]   upd_par;
    logic [ParW-1:0]   sig;
    pv       = ^item_q.value;
    st_valid = ram_rdata[EntryW-1];
    st_par   = ram_rdata[WordW +: ParW];
    st_xor   = ram_rdata[WordW-1:0];
    upd_xor  = st_valid ? (st_xor ^ item_q.old_value ^ item_q.value) : item_q.value;
    upd_par  = st_valid ? st_par : '0;

    run_xor_n = run_xor_q ^ item_q.value;
    run_par_n = run_par_q;
    for (int i = 0; i < CHUNK_MAX; i++) begin
      if (ChunkW'(i) == item_q.pos) begin
        run_par_n[i] = pv;
      end
    end
    for (int i = 0; i < ParW; i++) begin
      if (ChunkW'(i) == item_q.pos) begin
        upd_par[i] = pv;
      end
    end
    sig = {1'b0, run_par_n};
    for (int i = 0; i < ParW; i++) begin
      if (ChunkW'(i) == item_q.chunk) begin
        upd_par[i] = ^upd_xor;
        sig[i]     = ^run_xor_n;
      end
    end

    exec_we     = 1'b0;
    exec_wdata  = {1'b1, upd_par, upd_xor};
    exec_status = ST_ACCEPTED;
    exec_word   = run_xor_q;
    run_upd     = 1'b0;
    run_clr     = 1'b0;
    case (item_q.op)
      OP_NOP: begin
        exec_status = ST_ACCEPTED;
      end
      OP_RANGE: begin
        exec_status = ST_RANGE;
      end
      OP_UPDATE: begin
        exec_we     = 1'b1;
        exec_status = ST_STORED;
        exec_word   = upd_xor;
      end
      OP_RUN: begin
        exec_word = run_xor_n;
        if (!item_q.last) begin
          run_upd = 1'b1;
        end else begin
          run_clr = 1'b1;
          if (!item_q.check) begin
            exec_we     = 1'b1;
            exec_wdata  = {1'b1, sig, run_xor_n};
            exec_status = ST_STORED;
          end else if (!st_valid) begin
            exec_status = ST_NO_SIG;
          end else begin
            exec_status = (st_xor == run_xor_n && st_par == sig) ? ST_VERIFIED : ST_MISMATCH;
            exec_word   = st_xor;
          end
        end
      end
      default: exec_status = ST_ACCEPTED;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_q;
    ram_wdata = '0;
    load_out  = 1'b0;
    case (state_q)
      B_CLEAR: begin
        ram_we = 1'b1;
        if (clr_cnt_q == AddrW'(Depth - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          ram_re  = 1'b1;
          state_d = B_EXEC;
        end
      end
      B_EXEC: begin
        if (out_free) begin
          load_out  = 1'b1;
          ram_we    = exec_we;
          ram_waddr = addr_q;
          ram_wdata = exec_wdata;
          state_d   = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_cnt_q   <= '0;
      run_xor_q   <= '0;
      run_par_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (load_out) begin
        if (run_clr) begin
          run_xor_q <= '0;
          run_par_q <= '0;
        end else if (run_upd) begin
          run_xor_q <= run_xor_n;
          run_par_q <= run_par_n;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
      addr_q <= ram_raddr;
    end
    if (load_out) begin
      status_q <= exec_status;
      slot_q   <= item_q.slot[SlotOutW-1:0];
      word_q   <= exec_word;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.status          = status_q;
  assign result_o.chunk_slot      = slot_q;
  assign result_o.row_parity_word = word_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == B_EXEC) |->
      (item_q.op == OP_UPDATE) || (item_q.op == OP_RUN && item_q.last && !item_q.check))
    else $error("table written by an item that must not store");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && item_q.op == OP_RUN && item_q.last) |=> run_xor_q == '0 && run_par_q == '0)
    else $error("running state not cleared at chunk end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_CLEAR |-> !result_o.valid && !pop_o)
    else $error("activity during table clearing");

endmodule

/* design/block_parity_signature_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_parity_signature_engine
// Two-dimensional block parity: running XOR and per-word parity per chunk,
// signature table with store, check and incremental update.
// Flow: front accept, radix-16 divide of index / chunk size and hand into
//   the queue, then back table read, execute and a registered result beat;
//   the front takes no new item until the last is pushed into the queue.
// Reset: after rst_ni all ARRAY_COUNT * SLOTS_PER_ARRAY signature table
//   entries are cleared, one entry per cycle, with ready low; config is taken.
// ----------------------------------------------------------------------------
module block_parity_signature_engine #(
  parameter int unsigned CHUNK_MAX       = 32,
  parameter int unsigned SLOTS_PER_ARRAY = 256,
  parameter int unsigned ARRAY_COUNT     = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bps_pkg::ChunkW-1:0] cfg_wdata_i,
  bps_item_if.sink                   item_i,
  bps_result_if.source               result_o
);
  import bps_pkg::*;

  logic  push, full, pop, empty, clearing;
  item_t q_in, q_out;

  bps_front #(
    .CHUNK_MAX       (CHUNK_MAX),
    .SLOTS_PER_ARRAY (SLOTS_PER_ARRAY),
    .ARRAY_COUNT     (ARRAY_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .clearing_i  (clearing),
    .item_i      (item_i),
    .full_i      (full),
    .push_o      (push),
    .item_o      (q_in)
  );

  bps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (q_out)
  );

  bps_back #(
    .CHUNK_MAX       (CHUNK_MAX),
    .SLOTS_PER_ARRAY (SLOTS_PER_ARRAY),
    .ARRAY_COUNT     (ARRAY_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .item_i     (q_out),
    .pop_o      (pop),
    .clearing_o (clearing),
    .result_o   (result_o)
  );

endmodule

/* tb/block_parity_signature_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_parity_signature_engine_tb
// Self-checking bench for the block parity signature engine. A short
// directed table covers the index and value extremes, every command, and
// every status but mismatch: range, no stored signature, create-by-update
// and patch-by-update. After it, phases run at different chunk sizes, 0 and
// 63 among them. Most beats form generate passes, check passes (clean or
// corrupted) and element updates on tracked chunks. The rest are random
// noise beats, closed by a last-position generate word. A local signature
// model predicts each result beat that the table does not give, and the
// queue of pending results is compared field by field in arrival order.
// Both channels stall at random. One long output stall backs up the input.
// ----------------------------------------------------------------------------
module block_parity_signature_engine_tb;
  import bps_pkg::*;

  localparam int unsigned SlotCount   = 256;
  localparam int unsigned ArrayCount  = 4;
  localparam int unsigned ChunkMax    = 32;
  localparam int unsigned TableDepth  = SlotCount * ArrayCount;
  localparam int unsigned StallLimit  = 8000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseBeats  = 200;
  localparam int unsigned GapPercent  = 16;

  typedef struct packed {
    status_e             status;
    logic [SlotOutW-1:0] slot;
    logic [WordW-1:0]    word;
  } sig_result_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [AidW-1:0]  aid;
    logic [IdxW-1:0]  idx;
    logic [WordW-1:0] value;
    logic [WordW-1:0] old_value;
    logic             typed;
    sig_result_t      result;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i;
  logic [ChunkW-1:0] cfg_wdata_i;

  bps_item_if   item_bus ();
  bps_result_if result_bus ();

  block_parity_signature_engine uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_bus),
    .result_o   (result_bus)
  );

  always #1 clk_i = ~clk_i;

  // signature model state
  logic [WordW-1:0]  sig_xor [TableDepth];
  logic [ChunkMax:0] sig_par [TableDepth];
  bit                sig_known [TableDepth];
  logic [WordW-1:0]  acc_xor;
  logic [ChunkMax:0] acc_par;
  logic [ChunkW-1:0] chunk_reg;

  // chunk contents as last written by a generate pass or update, for building check passes
  logic [WordW-1:0] chunk_words [TableDepth][ChunkMax];
  bit               chunk_words_known [TableDepth];

  sig_result_t pending_results [$];
  int unsigned fail_count;
  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned phase_beats;
  int unsigned status_hits [6];
  bit          no_gaps;
  bit          hold_req;

  dir_row_t directed_rows [23] = '{
    '{CMD_GEN,    2'd0, 13'd0,    32'h0,        32'h0,        1'b1,
      '{ST_ACCEPTED, 8'd0,   32'h0}},
    '{CMD_UNUSED, 2'd3, 13'd8191, 32'hffffffff, 32'hffffffff, 1'b1,
      '{ST_ACCEPTED, 8'd255, 32'h0}},
    '{CMD_GEN,    2'd3, 13'd8191, 32'hffffffff, 32'h0,        1'b1,
      '{ST_RANGE,    8'd255, 32'h0}},
    '{CMD_UPDATE, 2'd2, 13'd2047, 32'hffffffff, 32'h0,        1'b1,
      '{ST_STORED,   8'd255, 32'hffffffff}},
    '{CMD_UPDATE, 2'd2, 13'd2040, 32'h1,        32'h0,        1'b1,
      '{ST_STORED,   8'd255, 32'hfffffffe}},
    '{CMD_CHECK,  2'd1, 13'd7,    32'h80000000, 32'h0,        1'b1,
      '{ST_NO_SIG,   8'd0,   32'h80000000}},
    '{CMD_GEN,    2'd0, 13'd8,    32'hffffffff, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_GEN,    2'd0, 13'd9,    32'h0,        32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_GEN,    2'd0, 13'd10,   32'h12345678, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_GEN,    2'd0, 13'd11,   32'h80000001, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_GEN,    2'd0, 13'd12,   32'ha5a5a5a5, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_GEN,    2'd0, 13'd13,   32'h00000001, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_GEN,    2'd0, 13'd14,   32'h7fffffff, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_GEN,    2'd0, 13'd15,   32'hdeadbeef, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_CHECK,  2'd0, 13'd8,    32'hffffffff, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_CHECK,  2'd0, 13'd9,    32'h0,        32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_CHECK,  2'd0, 13'd10,   32'h12345678, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_CHECK,  2'd0, 13'd11,   32'h80000001, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_CHECK,  2'd0, 13'd12,   32'ha5a5a5a5, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_CHECK,  2'd0, 13'd13,   32'h00000001, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_CHECK,  2'd0, 13'd14,   32'h7fffffff, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_CHECK,  2'd0, 13'd15,   32'hdeadbeef, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}},
    '{CMD_UPDATE, 2'd0, 13'd9,    32'h0000ffff, 32'h0, 1'b0, '{ST_ACCEPTED, 8'd0, 32'h0}}
  };

  function automatic sig_result_t predict_signature(input cmd_e cmd,
                                                    input logic [AidW-1:0] aid,
                                                    input logic [IdxW-1:0] idx,
                                                    input logic [WordW-1:0] value,
                                                    input logic [WordW-1:0] old_value);
    int unsigned       ch;
    int unsigned       slot;
    int unsigned       pos;
    int unsigned       t;
    logic [WordW-1:0]  x;
    logic [ChunkMax:0] p;
    sig_result_t       r;
    ch = chunk_reg;
    if (ch == 0) ch = 1;
    if (ch > ChunkMax) ch = ChunkMax;
    slot = idx / ch;
    pos = idx % ch;
    r.status = ST_ACCEPTED;
    r.slot = slot[SlotOutW-1:0];
    r.word = acc_xor;
    if (cmd != CMD_UNUSED) begin
      if (slot >= SlotCount || aid >= ArrayCount) begin
        r.status = ST_RANGE;
      end else begin
        t = aid * SlotCount + slot;
        if (cmd == CMD_UPDATE) begin
          if (sig_known[t]) begin
            x = sig_xor[t] ^ old_value ^ value;
            p = sig_par[t];
            p[pos] = ^value;
            p[ch] = ^x;
          end else begin
            x = value;
            p = '0;
            p[pos] = ^value;
            p[ch] = ^value;
          end
          sig_xor[t] = x;
          sig_par[t] = p;
          sig_known[t] = 1'b1;
          r.status = ST_STORED;
          r.word = x;
        end else begin
          acc_xor = acc_xor ^ value;
          acc_par[pos] = ^value;
          r.word = acc_xor;
          if (pos == ch - 1) begin
            p = acc_par;
            p[ch] = ^acc_xor;
            if (cmd == CMD_GEN) begin
              sig_xor[t] = acc_xor;
              sig_par[t] = p;
              sig_known[t] = 1'b1;
              r.status = ST_STORED;
            end else if (!sig_known[t]) begin
              r.status = ST_NO_SIG;
            end else begin
              r.status = (sig_xor[t] == acc_xor && sig_par[t] == p) ? ST_VERIFIED : ST_MISMATCH;
              r.word = sig_xor[t];
            end
            acc_xor = '0;
            acc_par = '0;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input cmd_e cmd, input logic [AidW-1:0] aid,
                           input logic [IdxW-1:0] idx, input logic [WordW-1:0] value,
                           input logic [WordW-1:0] old_value, input logic typed,
                           input sig_result_t typed_result);
    sig_result_t want;
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < GapPercent) begin
        item_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    item_bus.valid      <= 1'b1;
    item_bus.cmd        <= cmd;
    item_bus.array_id   <= aid;
    item_bus.elem_index <= idx;
    item_bus.value      <= value;
    item_bus.old_value  <= old_value;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    want = predict_signature(cmd, aid, idx, value, old_value);
    pending_results.insert(pending_results.size(), typed ? typed_result : want);
    beats_sent++;
    phase_beats++;
  endtask

  task automatic drain();
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // result side: check beats, random stalls, one long hold-off on request
  initial begin
    sig_result_t want;
    int unsigned hold_left;
    hold_left = 0;
    result_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (result_bus.valid && result_bus.ready) begin
        results_seen++;
        if (result_bus.status < 6) status_hits[result_bus.status]++;
        if (pending_results.size() == 0) begin
          $error("result beat with nothing pending: status %0d slot %0d word %h",
                 result_bus.status, result_bus.chunk_slot, result_bus.row_parity_word);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_bus.status);
            fail_count++;
          end
          if (result_bus.chunk_slot !== want.slot) begin
            $error("chunk_slot: expected %0d, got %0d", want.slot, result_bus.chunk_slot);
            fail_count++;
          end
          if (result_bus.row_parity_word !== want.word) begin
            $error("row_parity_word: expected %h, got %h", want.word,
                   result_bus.row_parity_word);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= no_gaps || ($urandom_range(0, 99) >= GapPercent);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [ChunkW-1:0] chunk_plan [9];
    logic [WordW-1:0]  vals [ChunkMax];
    logic [WordW-1:0]  tmp;
    int unsigned       ch;
    int unsigned       aid;
    int unsigned       slot;
    int unsigned       t;
    int unsigned       pick;
    int unsigned       idx;
    int unsigned       a;
    int unsigned       b;
    int unsigned       n;
    bit                hold_done;
    cmd_e              c;
    sig_result_t       none;

    item_bus.valid      <= 1'b0;
    item_bus.cmd        <= CMD_GEN;
    item_bus.array_id   <= '0;
    item_bus.elem_index <= '0;
    item_bus.value      <= '0;
    item_bus.old_value  <= '0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    chunk_plan = '{6'd3, 6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd5, 6'd16, 6'd8};
    none = '{ST_ACCEPTED, '0, '0};
    hold_done = 1'b0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    fail_count = 0;
    beats_sent = 0;
    results_seen = 0;
    foreach (sig_known[i]) sig_known[i] = 1'b0;
    foreach (chunk_words_known[i]) chunk_words_known[i] = 1'b0;
    foreach (status_hits[i]) status_hits[i] = 0;
    acc_xor = '0;
    acc_par = '0;
    chunk_reg = ChunkReset;
    chunk_plan[6] = ChunkW'($urandom_range(1, ChunkMax));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].cmd, directed_rows[i].aid, directed_rows[i].idx,
                directed_rows[i].value, directed_rows[i].old_value,
                directed_rows[i].typed, directed_rows[i].result);

    for (int phase = 0; phase < 9; phase++) begin
      drain();
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= chunk_plan[phase];
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      chunk_reg = chunk_plan[phase];
      foreach (chunk_words_known[i]) chunk_words_known[i] = 1'b0;
      ch = (chunk_reg == 0) ? 1 : ((chunk_reg > ChunkMax) ? ChunkMax : chunk_reg);
      no_gaps = (phase == 2);
      phase_beats = 0;
      while (phase_beats < PhaseBeats) begin
        if (phase == 5 && !hold_done && phase_beats >= 60) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        pick = $urandom_range(0, 99);
        aid = $urandom_range(0, ArrayCount - 1);
        slot = ($urandom_range(0, 3) == 0) ? SlotCount - 1 - $urandom_range(0, 2)
                                           : $urandom_range(0, 5);
        t = aid * SlotCount + slot;
        if (pick < 30) begin
          for (int k = 0; k < ch; k++) begin
            vals[k] = rand_word();
            chunk_words[t][k] = vals[k];
            send_beat(CMD_GEN, AidW'(aid), IdxW'(slot * ch + k), vals[k], rand_word(),
                      1'b0, none);
          end
          chunk_words_known[t] = 1'b1;
        end else if (pick < 55) begin
          for (int k = 0; k < ch; k++)
            vals[k] = chunk_words_known[t] ? chunk_words[t][k] : rand_word();
          if (chunk_words_known[t]) begin
            a = $urandom_range(0, ch - 1);
            b = $urandom_range(0, ch - 1);
            case ($urandom_range(0, 3))
              0: vals[a] = vals[a] ^ (32'h1 << $urandom_range(0, WordW - 1));
              1: begin
                // swap keeps the XOR word, only word parities may move
                tmp = vals[a];
                vals[a] = vals[b];
                vals[b] = tmp;
              end
              default: ;
            endcase
          end
          for (int k = 0; k < ch; k++)
            send_beat(CMD_CHECK, AidW'(aid), IdxW'(slot * ch + k), vals[k], rand_word(),
                      1'b0, none);
        end else if (pick < 72) begin
          a = $urandom_range(0, ch - 1);
          tmp = rand_word();
          send_beat(CMD_UPDATE, AidW'(aid), IdxW'(slot * ch + a), tmp,
                    chunk_words_known[t] ? chunk_words[t][a] : rand_word(), 1'b0, none);
          if (chunk_words_known[t]) chunk_words[t][a] = tmp;
        end else begin
          // noise beats, then a last-position generate word to clear the run
          n = $urandom_range(1, 4);
          repeat (n) begin
            c = cmd_e'($urandom_range(0, 3));
            a = $urandom_range(0, ArrayCount - 1);
            idx = $urandom_range(0, (1 << IdxW) - 1);
            if (idx / ch < SlotCount) chunk_words_known[a * SlotCount + idx / ch] = 1'b0;
            send_beat(c, AidW'(a), IdxW'(idx), $urandom, $urandom, 1'b0, none);
          end
          chunk_words_known[t] = 1'b0;
          send_beat(CMD_GEN, AidW'(aid), IdxW'(slot * ch + ch - 1), rand_word(), rand_word(),
                    1'b0, none);
        end
      end
    end
    no_gaps = 1'b0;
    drain();

    $display("Run: %0d input beats, %0d result beats over chunk sizes 8 (reset) and %0d settings.",
             beats_sent, results_seen, 9);
    $display("Statuses: %0d accepted, %0d stored, %0d verified, %0d mismatch,",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    $display("  %0d no signature, %0d range.", status_hits[4], status_hits[5]);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
